// File: hdl/tlbae_pkg.sv
package tlbae_pkg;

	localparam int FIELD_W = 20;
	localparam int AGE_W = 16;
	localparam int TOTAL_W = 32;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FILL = 1'b1;

	typedef struct packed {
		logic               func;
		logic [FIELD_W-1:0] vpn;
		logic [FIELD_W-1:0] pfn;
	} tlbae_in_t;

	typedef struct packed {
		logic               hit;
		logic [FIELD_W-1:0] frame_out;
		logic               evicted;
		logic [FIELD_W-1:0] evicted_page;
		logic [TOTAL_W-1:0] lookup_total;
		logic [TOTAL_W-1:0] miss_total;
	} tlbae_out_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} tlbae_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} tlbae_sts_t;

endpackage

// File: hdl/tlbae_ram.sv
module tlbae_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/tlbae_seq.sv
module tlbae_seq #(
	parameter int TLB_ENTRIES = 16,
	parameter int FRAME_BITS = 20,
	localparam int FW = (FRAME_BITS < tlbae_pkg::FIELD_W) ? FRAME_BITS : tlbae_pkg::FIELD_W,
	localparam int RW = tlbae_pkg::FIELD_W + FW + tlbae_pkg::AGE_W,
	localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlbae_pkg::tlbae_req_t req,
	input  tlbae_pkg::tlbae_in_t  item,
	output tlbae_pkg::tlbae_sts_t sts,
	output tlbae_pkg::tlbae_out_t res,
	output logic                 ram_we,
	output logic [IW-1:0]        ram_waddr,
	output logic [RW-1:0]        ram_wdata,
	output logic                 ram_re,
	output logic [IW-1:0]        ram_raddr,
	input  logic [RW-1:0]        ram_rdata
);

	localparam int FLD_W = tlbae_pkg::FIELD_W;
	localparam int AGE_W = tlbae_pkg::AGE_W;
	localparam int TOT_W = tlbae_pkg::TOTAL_W;
	localparam int CW = $clog2(TLB_ENTRIES + 1);
	localparam logic [CW-1:0] NCNT = CW'(TLB_ENTRIES);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOOK  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_WRITE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	tlbae_pkg::tlbae_in_t item_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rd_cnt_q;
	logic             rv_s1;
	logic [IW-1:0]    ra_s1;
	logic             hit_q;
	logic [FW-1:0]    frame_q;
	logic             evicted_q;
	logic [FLD_W-1:0] vpage_q;
	logic [AGE_W-1:0] best_q;
	logic [IW-1:0]    victim_q;
	logic [TOT_W-1:0] lookups_q;
	logic [TOT_W-1:0] misses_q;

	logic [FLD_W-1:0] r_page;
	logic [FW-1:0]    r_frame;
	logic [AGE_W-1:0] r_age;
	logic [AGE_W-1:0] new_age;
	logic             match;
	logic             drained;

	assign r_page  = ram_rdata[RW-1 -: FLD_W];
	assign r_frame = ram_rdata[AGE_W +: FW];
	assign r_age   = ram_rdata[AGE_W-1:0];
	assign match   = (r_page == item_q.vpn);
	assign ram_raddr = rd_cnt_q[IW-1:0];
	assign drained = !ram_re && !rv_s1;

	always_comb begin
		if (match) begin
			new_age = '0;
		end else if (r_age != tlbae_pkg::AGE_MAX) begin
			new_age = r_age + AGE_W'(1);
		end else begin
			new_age = r_age;
		end
	end

	always_comb begin
		ram_re = 1'b0;
		ram_we = 1'b0;
		ram_waddr = ra_s1;
		ram_wdata = {r_page, r_frame, new_age};
		unique case (state_q)
			S_LOOK: begin
				ram_re = (rd_cnt_q < cnt_q);
				ram_we = rv_s1;
			end
			S_SCAN: begin
				ram_re = (rd_cnt_q < NCNT);
			end
			S_SHIFT: begin
				// move each later entry up by one place
				ram_re = (rd_cnt_q < NCNT);
				ram_we = rv_s1;
				ram_waddr = ra_s1 - IW'(1);
				ram_wdata = ram_rdata;
			end
			S_WRITE: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[IW-1:0];
				ram_wdata = {item_q.vpn, item_q.pfn[FW-1:0], {AGE_W{1'b0}}};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_cnt_q  <= '0;
			rv_s1     <= 1'b0;
			lookups_q <= '0;
			misses_q  <= '0;
		end else begin
			rv_s1 <= ram_re;
			rd_cnt_q <= rd_cnt_q + CW'(ram_re);
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						rd_cnt_q <= '0;
						if (item.func == tlbae_pkg::FUNC_LOOKUP) begin
							lookups_q <= lookups_q + TOT_W'(1);
							state_q <= S_LOOK;
						end else if (cnt_q == NCNT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_LOOK: begin
					if (drained) begin
						if (!hit_q) begin
							misses_q <= misses_q + TOT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (drained) begin
						rd_cnt_q <= CW'(victim_q) + CW'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (drained) begin
						cnt_q <= NCNT - CW'(1);
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					cnt_q <= cnt_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (req.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ra_s1 <= ram_raddr;
		if (state_q == S_IDLE && req.start) begin
			item_q    <= item;
			hit_q     <= 1'b0;
			frame_q   <= '0;
			evicted_q <= 1'b0;
			vpage_q   <= '0;
		end
		if (state_q == S_LOOK && rv_s1 && match) begin
			// keep the frame of the last match
			hit_q   <= 1'b1;
			frame_q <= r_frame;
		end
		if (state_q == S_SCAN) begin
			if (rv_s1 && (ra_s1 == '0 || r_age > best_q)) begin
				best_q   <= r_age;
				victim_q <= ra_s1;
				vpage_q  <= r_page;
			end
			if (drained) begin
				evicted_q <= 1'b1;
			end
		end
	end

	assign sts.idle = (state_q == S_IDLE);
	assign sts.done = (state_q == S_DONE) && req.out_free;

	assign res.hit          = hit_q;
	assign res.frame_out    = FLD_W'(frame_q);
	assign res.evicted      = evicted_q;
	assign res.evicted_page = vpage_q;
	assign res.lookup_total = lookups_q;
	assign res.miss_total   = misses_q;

endmodule

// File: hdl/tlb_with_age_based_eviction.sv
// Processing: a lookup reads each valid entry once and writes back its updated age; a fill
// with room writes the new entry directly; a fill into a full TLB first scans every age to
// pick the victim, then closes up the entries after it. A stalled output holds the sequencer.
// Throughput: one item at a time; the next item can be taken in the cycle after a result is
// registered, and it is processed while the finished one waits in the output register.
// Reset (arst_n low, asynchronous) empties the TLB and clears both counters; RAM keeps its data.
module tlb_with_age_based_eviction #(
	parameter int TLB_ENTRIES = 16,
	parameter int FRAME_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tlbae_pkg::tlbae_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tlbae_pkg::tlbae_out_t out_data
);

	localparam int FW = (FRAME_BITS < tlbae_pkg::FIELD_W) ? FRAME_BITS : tlbae_pkg::FIELD_W;
	localparam int RW = tlbae_pkg::FIELD_W + FW + tlbae_pkg::AGE_W;
	localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	tlbae_pkg::tlbae_req_t req;
	tlbae_pkg::tlbae_sts_t sts;
	tlbae_pkg::tlbae_out_t res;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	logic out_valid_q;
	tlbae_pkg::tlbae_out_t out_q;

	assign in_ready     = sts.idle;
	assign req.start    = in_valid && sts.idle;
	assign req.out_free = !out_valid_q || out_ready;

	tlbae_seq #(
		.TLB_ENTRIES(TLB_ENTRIES),
		.FRAME_BITS(FRAME_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.item(in_data),
		.sts(sts),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	tlbae_ram #(
		.WIDTH(RW),
		.DEPTH(TLB_ENTRIES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: verif/tb.sv
module tb;
	import tlbae_pkg::*;

	localparam int TLB_N = 16;
	localparam int FRAME_N = 20;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int POOL_N = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tlbae_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tlbae_out_t out_data;

	tlb_with_age_based_eviction #(
		.TLB_ENTRIES(TLB_N),
		.FRAME_BITS(FRAME_N)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the translation buffer
	logic [FIELD_W-1:0] ent_page [TLB_N];
	logic [FIELD_W-1:0] ent_frame [TLB_N];
	logic [AGE_W-1:0] ent_age [TLB_N];
	int ent_count = 0;
	logic [TOTAL_W-1:0] lookups_cnt = '0;
	logic [TOTAL_W-1:0] misses_cnt = '0;

	tlbae_in_t tlb_requests[$];
	tlbae_out_t expected_translations[$];
	logic [FIELD_W-1:0] page_pool [POOL_N];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int evictions_seen = 0;
	int cycles = 0;

	function automatic tlbae_out_t apply_request(tlbae_in_t req);
		tlbae_out_t res;
		int i;
		int victim;
		logic [AGE_W-1:0] oldest;
		res = '0;
		if (req.func == FUNC_LOOKUP) begin
			lookups_cnt = lookups_cnt + 1'b1;
			for (i = 0; i < ent_count; i++) begin
				if (ent_page[i] == req.vpn) begin
					ent_age[i] = '0;
					res.hit = 1'b1;
					res.frame_out = ent_frame[i];
				end else if (ent_age[i] != AGE_MAX) begin
					ent_age[i] = ent_age[i] + 1'b1;
				end
			end
			if (!res.hit)
				misses_cnt = misses_cnt + 1'b1;
		end else begin
			if (ent_count >= TLB_N) begin
				// earliest entry with the greatest age goes
				victim = 0;
				oldest = ent_age[0];
				for (i = 1; i < TLB_N; i++) begin
					if (ent_age[i] > oldest) begin
						oldest = ent_age[i];
						victim = i;
					end
				end
				res.evicted = 1'b1;
				res.evicted_page = ent_page[victim];
				for (i = victim; i + 1 < TLB_N; i++) begin
					ent_page[i] = ent_page[i + 1];
					ent_frame[i] = ent_frame[i + 1];
					ent_age[i] = ent_age[i + 1];
				end
				ent_count = TLB_N - 1;
			end
			ent_page[ent_count] = req.vpn;
			ent_frame[ent_count] = req.pfn & FIELD_W'((64'd1 << FRAME_N) - 1);
			ent_age[ent_count] = '0;
			ent_count++;
		end
		res.lookup_total = lookups_cnt;
		res.miss_total = misses_cnt;
		return res;
	endfunction

	// driver: take the next item once the current one is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_translations.push_back(apply_request(in_data));
			if (!in_valid || in_ready) begin
				if (tlb_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= tlb_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		tlbae_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_translations.size() == 0) begin
					$error("unexpected result: %0h", out_data);
					mismatches++;
				end else begin
					want = expected_translations.pop_front();
					hits_seen += want.hit;
					evictions_seen += want.evicted;
					check_field("hit", want.hit, out_data.hit);
					check_field("frame_out", want.frame_out, out_data.frame_out);
					check_field("evicted", want.evicted, out_data.evicted);
					check_field("evicted_page", want.evicted_page, out_data.evicted_page);
					check_field("lookup_total", want.lookup_total, out_data.lookup_total);
					check_field("miss_total", want.miss_total, out_data.miss_total);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_req(logic func, logic [FIELD_W-1:0] page, logic [FIELD_W-1:0] frame);
		tlbae_in_t req;
		req.func = func;
		req.vpn = page;
		req.pfn = frame;
		tlb_requests.push_back(req);
	endtask

	// hold until every queued item is accepted and answered
	task automatic drain();
		while (tlb_requests.size() != 0 || in_valid || expected_translations.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_mix(int send_pct, int stall_pct, int count);
		int k;
		logic [FIELD_W-1:0] page;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 75)
				page = page_pool[$urandom_range(POOL_N - 1)];
			else
				page = FIELD_W'($urandom);
			if ($urandom_range(99) < 60)
				push_req(FUNC_LOOKUP, page, FIELD_W'($urandom));
			else
				push_req(FUNC_FILL, page, FIELD_W'($urandom));
		end
		drain();
	endtask

	initial begin
		int k;
		foreach (page_pool[k])
			page_pool[k] = FIELD_W'($urandom);
		page_pool[0] = '0;
		page_pool[1] = '1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lookup on an empty buffer, then two entries at the page extremes
		push_req(FUNC_LOOKUP, '0, '1);
		push_req(FUNC_FILL, '0, '1);
		push_req(FUNC_FILL, '1, '0);
		// age both entries with misses
		for (k = 0; k < 30; k++)
			push_req(FUNC_LOOKUP, FIELD_W'($urandom_range(1, 20'hFFFFE)), FIELD_W'($urandom));
		for (k = 2; k < TLB_N; k++)
			push_req(FUNC_FILL, page_pool[k], FIELD_W'($urandom));
		// two equally aged entries tie, then all ages equal
		push_req(FUNC_FILL, page_pool[16], 20'h5A5A5);
		push_req(FUNC_FILL, page_pool[17], 20'hA5A5A);
		push_req(FUNC_FILL, page_pool[18], '1);
		// duplicate page: lookup returns the later frame
		push_req(FUNC_FILL, page_pool[5], 20'h12345);
		push_req(FUNC_FILL, page_pool[5], 20'hEDCBA);
		push_req(FUNC_LOOKUP, page_pool[5], '0);
		push_req(FUNC_LOOKUP, '1, '1);
		push_req(FUNC_FILL, '1, '1);
		push_req(FUNC_LOOKUP, '1, '0);
		push_req(FUNC_LOOKUP, page_pool[10], '1);
		push_req(FUNC_FILL, page_pool[19], '0);
		drain();

		run_mix(0, 0, 135);
		run_mix(45, 0, 135);
		run_mix(0, 45, 135);
		run_mix(24, 24, 135);
		repeat (100) @(negedge clk);

		$display("Checked %0d results (%0d lookup hits, %0d evictions) across four traffic mixes,",
			results_seen, hits_seen, evictions_seen);
		$display("including empty-buffer lookups, eviction ties and duplicate page fills.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
hdl/tlbae_pkg.sv
hdl/tlbae_ram.sv
hdl/tlbae_seq.sv
hdl/tlb_with_age_based_eviction.sv
verif/tb.sv
